// File: rtl/skts_pkg.sv
// ----------------------------------------------------------------------------
// skts_pkg
// Shared types and constants for the sorted key table search block.
// ----------------------------------------------------------------------------
package skts_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int KEY_BITS    = 32;

  // stream field widths
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int FOUND_BITS  = 6;

  // config port
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  localparam logic REG_TABLE_SIZE = 1'b0;  // word select, paddr[2]

  // operation codes
  localparam logic [OP_BITS-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_CHECK  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_BITS-1:0] OP_NOP    = 2'd3;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_ORDERED = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_INVALID     = 2'd3;

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [OP_BITS-1:0]     op_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  // key memory access from the sequencer
  typedef struct packed {
    logic wr_en;
    idx_t wr_addr;
    key_t wr_data;
    idx_t rd_addr;
  } ram_req_t;

  // comparator flags: a == b, a < b
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

  // one result toward the output register
  typedef struct packed {
    status_t                 status;
    logic [FOUND_BITS-1:0]   found_index;
  } result_t;

  // midpoint of the half-open range [lo, hi), hi > lo
  function automatic idx_t mid_of(input cnt_t lo, input cnt_t hi);
    cnt_t span;
    cnt_t sum;
    span = hi - lo - cnt_t'(1);
    sum  = lo + (span >> 1);
    return sum[IDX_BITS-1:0];
  endfunction

endpackage

// File: rtl/sorted_key_table_search.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Key table with entry writes, strict-ordering check and binary search.
// ----------------------------------------------------------------------------
// One request is worked at a time; s_axis_tready is high only while the
// sequencer is idle, and the finished result sits in an output register so
// the next request can enter while it waits. Each step of a check or search
// is one registered read of the key memory plus one pass through the shared
// comparator: a search makes one step per probe (at most 7 probes for 64
// entries), a check one step per slot walked (up to table_size), and a write
// or unused op no step. table_size above 64 is treated as 64. Slots read by
// a check or search must have been written.
module sorted_key_table_search (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op[1:0], entry_index[7:2], key[39:8]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // status[1:0], found_index[7:2]
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [skts_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [skts_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [skts_pkg::APB_DATA_BITS-1:0] prdata,
  output logic        pready
);
  import skts_pkg::*;

  cnt_t     table_size;
  cnt_t     n_used;
  ram_req_t ram_req;
  key_t     rd_data;
  key_t     cmp_b;
  cmp_res_t cmp;
  logic     done_valid;
  logic     done_ready;
  result_t  result;
  result_t  out_reg;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_SIZE)) begin
      table_size <= pwdata[CNT_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TABLE_SIZE) ?
                  {{(APB_DATA_BITS-CNT_BITS){1'b0}}, table_size} : '0;

  // slots in use, saturated at the table depth
  assign n_used = (table_size > cnt_t'(TABLE_DEPTH)) ? cnt_t'(TABLE_DEPTH) : table_size;

  skts_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .op          (s_axis_tdata[1:0]),
    .entry_index (s_axis_tdata[7:2]),
    .key         (s_axis_tdata[39:8]),
    .n_used      (n_used),
    .ram_req     (ram_req),
    .rd_data     (rd_data),
    .cmp_b       (cmp_b),
    .cmp         (cmp),
    .done_valid  (done_valid),
    .done_ready  (done_ready),
    .result      (result)
  );

  skts_key_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  skts_cmp u_cmp (
    .a   (rd_data),
    .b   (cmp_b),
    .res (cmp)
  );

  // output register
  assign done_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done_ready) begin
      m_axis_tvalid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      out_reg <= result;
    end
  end

  assign m_axis_tdata = {out_reg.found_index, out_reg.status};

endmodule

// File: rtl/skts_key_ram.sv
// ----------------------------------------------------------------------------
// skts_key_ram
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skts_key_ram (
  input  logic            clk,
  input  skts_pkg::ram_req_t req,
  output skts_pkg::key_t  rd_data
);
  import skts_pkg::*;

  key_t mem [TABLE_DEPTH];

  // write and synchronous read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

// File: rtl/skts_cmp.sv
// ----------------------------------------------------------------------------
// skts_cmp
// Shared key comparator used by both the ordering walk and the search.
// ----------------------------------------------------------------------------
module skts_cmp (
  input  skts_pkg::key_t     a,
  input  skts_pkg::key_t     b,
  output skts_pkg::cmp_res_t res
);
  import skts_pkg::*;

  // unsigned magnitude compare
  assign res.eq = (a == b);
  assign res.lt = (a < b);

endmodule

// File: rtl/skts_seq.sv
// ----------------------------------------------------------------------------
// skts_seq
// Sequencer: takes one request, steps the key memory and the comparator
// once per cycle, and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module skts_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  skts_pkg::op_t       op,
  input  skts_pkg::idx_t      entry_index,
  input  skts_pkg::key_t      key,
  input  skts_pkg::cnt_t      n_used,
  output skts_pkg::ram_req_t  ram_req,
  input  skts_pkg::key_t      rd_data,
  output skts_pkg::key_t      cmp_b,
  input  skts_pkg::cmp_res_t  cmp,
  output logic                done_valid,
  input  logic                done_ready,
  output skts_pkg::result_t   result
);
  import skts_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  idx_t       pos, pos_next;        // slot being probed
  cnt_t       left, left_next;      // search range [left, hi)
  cnt_t       hi, hi_next;
  key_t       operand, operand_next; // search key or last key seen
  status_t    status, status_next;
  idx_t       found, found_next;

  cnt_t       srch_left;
  cnt_t       srch_hi;
  idx_t       srch_mid;
  logic       accept;

  assign accept = in_valid && in_ready;

  // narrowed search range after the current probe
  always_comb begin
    if (cmp.lt) begin
      srch_left = {1'b0, pos} + cnt_t'(1);
      srch_hi   = hi;
    end else begin
      srch_left = left;
      srch_hi   = {1'b0, pos};
    end
  end

  assign srch_mid = mid_of(srch_left, srch_hi);

  // next-state logic
  always_comb begin
    state_next   = state;
    pos_next     = pos;
    left_next    = left;
    hi_next      = hi;
    operand_next = operand;
    status_next  = status;
    found_next   = found;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          status_next = ST_OK;
          found_next  = '0;
          unique case (op)
            OP_CHECK: begin
              if (n_used == '0) begin
                status_next = ST_INVALID;
                state_next  = S_DONE;
              end else begin
                pos_next     = '0;
                operand_next = '0;
                state_next   = S_CHK;
              end
            end
            OP_SEARCH: begin
              if (n_used == '0) begin
                status_next = ST_NOT_FOUND;
                state_next  = S_DONE;
              end else begin
                left_next    = '0;
                hi_next      = n_used;
                pos_next     = mid_of('0, n_used);
                operand_next = key;
                state_next   = S_SRCH;
              end
            end
            OP_WRITE, OP_NOP: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_CHK: begin
        // need rd_data > last key
        if (!cmp.lt && !cmp.eq) begin
          if (({1'b0, pos} + cnt_t'(1)) == n_used) begin
            status_next = ST_OK;
            state_next  = S_DONE;
          end else begin
            pos_next     = pos + idx_t'(1);
            operand_next = rd_data;
          end
        end else begin
          status_next = ST_NOT_ORDERED;
          state_next  = S_DONE;
        end
      end
      S_SRCH: begin
        if (cmp.eq) begin
          found_next  = pos;
          status_next = ST_OK;
          state_next  = S_DONE;
        end else begin
          left_next = srch_left;
          hi_next   = srch_hi;
          if (srch_left >= srch_hi) begin
            status_next = ST_NOT_FOUND;
            state_next  = S_DONE;
          end else begin
            pos_next = srch_mid;
          end
        end
      end
      S_DONE: begin
        if (done_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    left    <= left_next;
    hi      <= hi_next;
    operand <= operand_next;
    status  <= status_next;
    found   <= found_next;
  end

  // memory: address the next probe so its data lands with the state
  assign ram_req.wr_en   = accept && (op == OP_WRITE);
  assign ram_req.wr_addr = entry_index;
  assign ram_req.wr_data = key;
  assign ram_req.rd_addr = pos_next;

  assign cmp_b              = operand;
  assign in_ready           = (state == S_IDLE);
  assign done_valid         = (state == S_DONE);
  assign result.status      = status;
  assign result.found_index = found;

`ifndef ASSERT_OFF
  a_srch_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |-> ({1'b0, pos} < n_used))
    else $error("search probe outside used slots");

  a_chk_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> ({1'b0, pos} < n_used))
    else $error("ordering walk outside used slots");

  a_srch_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |-> (left <= cnt_t'(pos)) && (cnt_t'(pos) < hi))
    else $error("probe outside search range");

  a_empty_chk: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_CHECK && n_used == '0 |=> state == S_DONE && status == ST_INVALID)
    else $error("empty table check not reported invalid");
`endif

endmodule
